FILE: rtl/core/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg: shared types and constants of the multichannel FIR predictor
// Transaction payload structs, command codes, field widths and defaults.
// ----------------------------------------------------------------------------
package mfp_pkg;

   localparam int CIDX_W  = 8;    // coefficient address field
   localparam int COEF_W  = 16;   // Q1.14 tap
   localparam int SAMP_W  = 16;   // input sample
   localparam int CH_W    = 3;    // reported channel index
   localparam int PRED_W  = 20;   // saturated prediction
   localparam int SHIFT_W = 5;    // result_shift register

   localparam int COEF_DEPTH = 2 ** CIDX_W;

   localparam int PRED_MAX = 524287;
   localparam int PRED_MIN = -524288;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;

   localparam int NCH_DEFAULT   = 8;
   localparam int ORDER_DEFAULT = 4;

   typedef enum logic {
      CMD_COEF   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic        [CIDX_W-1:0]   coef_index;
      logic signed [COEF_W-1:0]   coef_value;
      logic signed [SAMP_W-1:0]   sample;
   } req_type;

   typedef struct packed {
      logic        [CH_W-1:0]     out_channel;
      logic signed [PRED_W-1:0]   prediction;
      logic                       primed;
      logic                       last;
   } rsp_type;

endpackage

FILE: rtl/core/mimo_fir_predictor_top.sv
// ----------------------------------------------------------------------------
// mimo_fir_predictor_top: multichannel linear predictor
// Loads taps, collects sample frames into a history ring and computes one
// prediction per channel with a single shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  req_     in   req_valid/req_stall   req_type: cmd, coef_index, coef_value, sample
//  rsp_     out  rsp_valid/rsp_stall   rsp_type: out_channel, prediction, primed, last
//  csr_     in   csr_valid/csr_ready   result_shift (5 bits), always ready
//
//  Sequence: a coefficient transaction or a sample that does not close a frame
//  leaves the block idle. A frame-closing sample starts the result sequence:
//  once primed, the one shared MAC works through ORDER*NCH taps per predicted
//  channel, then pipeline drain, rounding, shifting and the output load; before
//  priming it is one emit per channel. req_stall is high for the whole sequence.
//  Reset: synchronous, active high; history needs no clearing pass since every
//  slot is rewritten before the first primed frame reads it.
//  Stalls: rsp_stall holds the output register; the sequencer waits in its
//  emit step until the register frees up. New transactions are taken again as
//  soon as the last result sits in the output register.
//
module mimo_fir_predictor_top
   import mfp_pkg::*;
#(
   parameter int NCH   = NCH_DEFAULT,
   parameter int ORDER = ORDER_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SHIFT_W-1:0]   csr_data
);

   localparam int NTAPS      = ORDER * NCH * NCH;
   localparam int HIST_DEPTH = ORDER * NCH;
   localparam int SW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int TW    = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int HA_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CA_W  = (NTAPS > 1) ? $clog2(NTAPS) : 1;
   localparam int FS_W  = $clog2(ORDER + 2);
   localparam int PROD_W = COEF_W + SAMP_W;
   // products are at most 2^30 in size; headroom for HIST_DEPTH terms plus rounding
   localparam int ACC_W = PROD_W + ((HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 0) + 1;

   localparam logic [SW-1:0]    LAST_CH   = SW'(NCH - 1);
   localparam logic [TW-1:0]    LAST_ST   = TW'(ORDER - 1);
   localparam logic [FS_W-1:0]  FS_FULL   = FS_W'(ORDER + 1);
   localparam logic [CA_W-1:0]  C_NCH     = CA_W'(NCH);
   localparam logic [CA_W-1:0]  C_STEP    = CA_W'(NCH * NCH - NCH + 1);
   localparam logic [HA_W-1:0]  H_NCH     = HA_W'(NCH);
   localparam logic [HA_W-1:0]  H_TOP     = HA_W'((ORDER - 1) * NCH);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(PRED_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(PRED_MIN);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MAC   = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_SHIFT = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   // memories
   logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
   logic signed [SAMP_W-1:0] hist_mem [HIST_DEPTH];
   logic signed [COEF_W-1:0] coef_rd_ff;
   logic signed [SAMP_W-1:0] hist_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // control state
   state_type          state_ff, state_in;
   logic [SW-1:0]      pos_ff, pos_in;        // next channel of the frame
   logic [TW-1:0]      head_ff, head_in;      // slot the next frame lands in
   logic [HA_W-1:0]    wbase_ff, wbase_in;    // head_ff * NCH
   logic [FS_W-1:0]    fs_ff, fs_in;          // frames seen, saturating
   logic               v1_ff, v1_in;          // read data valid
   logic               v2_ff;                 // product valid
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;

   // sequencer working registers
   logic               primed_ff, primed_in;
   logic [TW-1:0]      cur_slot_ff, cur_slot_in;
   logic [HA_W-1:0]    cur_base_ff, cur_base_in;
   logic [SW-1:0]      p_ff, p_in;
   logic [CA_W-1:0]    pbase_ff, pbase_in;
   logic [CA_W-1:0]    caddr_ff, caddr_in;
   logic [SW-1:0]      src_ff, src_in;
   logic [TW-1:0]      st_ff, st_in;
   logic [TW-1:0]      slot_ff, slot_in;
   logic [HA_W-1:0]    hbase_ff, hbase_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PRED_W-1:0] pred_ff, pred_in;
   rsp_type            rsp_ff, rsp_in;

   logic               coef_we, hist_we, out_free, p_last;
   logic [HA_W-1:0]    hist_waddr, hist_raddr;
   logic [FS_W-1:0]    fs_next;
   logic signed [ACC_W-1:0] rnd, shifted;

   assign hist_waddr = wbase_ff + HA_W'(pos_ff);
   assign hist_raddr = hbase_ff + HA_W'(src_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign p_last     = (p_ff == LAST_CH);
   assign fs_next    = (fs_ff < FS_FULL) ? fs_ff + FS_W'(1) : fs_ff;
   assign rnd        = (shift_ff == '0) ? '0 : (ACC_W'(1) <<< (shift_ff - SHIFT_W'(1)));
   assign shifted    = acc_ff >>> shift_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      wbase_in     = wbase_ff;
      fs_in        = fs_ff;
      v1_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      shift_in     = shift_ff;
      primed_in    = primed_ff;
      cur_slot_in  = cur_slot_ff;
      cur_base_in  = cur_base_ff;
      p_in         = p_ff;
      pbase_in     = pbase_ff;
      caddr_in     = caddr_ff;
      src_in       = src_ff;
      st_in        = st_ff;
      slot_in      = slot_ff;
      hbase_in     = hbase_ff;
      acc_in       = acc_ff;
      pred_in      = pred_ff;
      rsp_in       = rsp_ff;
      coef_we      = 1'b0;
      hist_we      = 1'b0;

      if (csr_valid) begin
         shift_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == CMD_COEF) begin
                  coef_we = (int'(req_data.coef_index) < NTAPS);
               end else begin
                  hist_we = 1'b1;
                  if (pos_ff == LAST_CH) begin
                     // frame closed: step 0 is the slot just filled
                     pos_in      = '0;
                     fs_in       = fs_next;
                     primed_in   = (fs_next >= FS_FULL);
                     cur_slot_in = head_ff;
                     cur_base_in = wbase_ff;
                     slot_in     = head_ff;
                     hbase_in    = wbase_ff;
                     if (head_ff == LAST_ST) begin
                        head_in  = '0;
                        wbase_in = '0;
                     end else begin
                        head_in  = head_ff + TW'(1);
                        wbase_in = wbase_ff + H_NCH;
                     end
                     p_in     = '0;
                     pbase_in = '0;
                     caddr_in = '0;
                     src_in   = '0;
                     st_in    = '0;
                     acc_in   = '0;
                     pred_in  = '0;
                     state_in = (fs_next >= FS_FULL) ? ST_MAC : ST_EMIT;
                  end else begin
                     pos_in = pos_ff + SW'(1);
                  end
               end
            end
         end
         ST_MAC: begin
            v1_in = 1'b1;
            if (src_ff == LAST_CH) begin
               src_in   = '0;
               caddr_in = caddr_ff + C_STEP;
               // walk back one frame in the ring
               if (slot_ff == '0) begin
                  slot_in  = LAST_ST;
                  hbase_in = H_TOP;
               end else begin
                  slot_in  = slot_ff - TW'(1);
                  hbase_in = hbase_ff - H_NCH;
               end
               if (st_ff == LAST_ST) begin
                  state_in = ST_DRAIN;
               end else begin
                  st_in = st_ff + TW'(1);
               end
            end else begin
               src_in   = src_ff + SW'(1);
               caddr_in = caddr_ff + CA_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            acc_in   = acc_ff + rnd;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (shifted > SAT_HI) begin
               pred_in = PRED_W'(SAT_HI);
            end else if (shifted < SAT_LO) begin
               pred_in = PRED_W'(SAT_LO);
            end else begin
               pred_in = PRED_W'(shifted);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_channel = CH_W'(p_ff);
               rsp_in.prediction  = pred_ff;
               rsp_in.primed      = primed_ff;
               rsp_in.last        = p_last;
               if (p_last) begin
                  state_in = ST_IDLE;
               end else begin
                  p_in     = p_ff + SW'(1);
                  pbase_in = pbase_ff + C_NCH;
                  caddr_in = pbase_ff + C_NCH;
                  src_in   = '0;
                  st_in    = '0;
                  slot_in  = cur_slot_ff;
                  hbase_in = cur_base_ff;
                  acc_in   = '0;
                  state_in = primed_ff ? ST_MAC : ST_EMIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         head_ff      <= '0;
         wbase_ff     <= '0;
         fs_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= SHIFT_RESET;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         head_ff      <= head_in;
         wbase_ff     <= wbase_in;
         fs_ff        <= fs_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= shift_in;
      end
   end

   // shared MAC: read, multiply, accumulate
   always_ff @(posedge clock) begin
      primed_ff   <= primed_in;
      cur_slot_ff <= cur_slot_in;
      cur_base_ff <= cur_base_in;
      p_ff        <= p_in;
      pbase_ff    <= pbase_in;
      caddr_ff    <= caddr_in;
      src_ff      <= src_in;
      st_ff       <= st_in;
      slot_ff     <= slot_in;
      hbase_ff    <= hbase_in;
      pred_ff     <= pred_in;
      rsp_ff      <= rsp_in;
      prod_ff     <= coef_rd_ff * hist_rd_ff;
      if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[req_data.coef_index] <= req_data.coef_value;
      end
      coef_rd_ff <= coef_mem[CIDX_W'(caddr_ff)];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= req_data.sample;
      end
      hist_rd_ff <= hist_mem[hist_raddr];
   end

`ifndef SYNTH
   a_unprimed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.primed) |-> (rsp_data.prediction == '0))
      else $error("unprimed result carries a nonzero prediction");

   a_frame_end_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.cmd == CMD_SAMPLE && pos_ff == LAST_CH)
      |=> req_stall)
      else $error("frame end did not start the result sequence");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (!v1_ff && !v2_ff))
      else $error("rounding started with MAC pipeline busy");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && rsp_stall)
      |=> (state_ff == ST_EMIT && rsp_valid_ff))
      else $error("output register overwritten while stalled");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (int'(caddr_ff) < NTAPS))
      else $error("tap address out of range");
`endif

endmodule

FILE: tb/sv/tb_mimo_fir_predictor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mimo_fir_predictor_top: self-checking bench for the multichannel predictor
// Drives tap loads and sample frames with random valid/stall throttling on both
// channels. A cycle-free model of the filter forecasts every channel result,
// and each result is compared field by field in arrival order. The result
// shift is swept through its extremes between traffic phases.
// ----------------------------------------------------------------------------
module tb_mimo_fir_predictor_top;
   import mfp_pkg::*;

   localparam int NCH       = NCH_DEFAULT;
   localparam int ORDER     = ORDER_DEFAULT;
   localparam int TAP_COUNT = ORDER * NCH * NCH;

   localparam int RESET_CYCLES   = 7;
   localparam int IDLE_PCT       = 19;    // chance per cycle of a valid gap or a stall
   localparam int RANDOM_ITEMS   = 36;    // the full tap load already takes most of the run
   localparam int SEGMENT_ITEMS  = 12;
   localparam int SETTLE_CYCLES  = 16;    // transactions that close no frame are long done by then
   localparam int END_CYCLES     = 64;
   // Longest legal silence is the work for one predicted channel of a primed
   // frame, stretched by output stalls; the limit is well above that.
   localparam int WATCHDOG_LIMIT = 2000;

   // DUT-facing signals; the inputs are known from time zero
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SHIFT_W-1:0]   csr_data  = '0;

   // When set, neither side inserts gaps or stalls
   bit steady = 1'b0;

   // Filter model state: tap store, history ring, frame fill position
   logic signed [COEF_W-1:0] tap_model [TAP_COUNT];
   logic signed [SAMP_W-1:0] hist_model [ORDER][NCH];
   int                       fill_pos    = 0;
   int                       ring_head   = 0;
   int                       frames_done = 0;
   logic [SHIFT_W-1:0]       shift_model = SHIFT_RESET;

   // Forecast channel results, oldest first
   rsp_type forecast_q[$];

   int n_errors       = 0;
   int n_checked      = 0;
   int n_frames       = 0;
   int n_tap_writes   = 0;
   int n_shift_writes = 0;

   mimo_fir_predictor_top #(
      .NCH   (NCH),
      .ORDER (ORDER)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      for (int s = 0; s < ORDER; s++)
         for (int c = 0; c < NCH; c++)
            hist_model[s][c] = '0;
   end

   // ------------------------------------------------------------------------
   // Filter model
   // ------------------------------------------------------------------------

   // Frame just closed: one forecast per predicted channel. Until ORDER+1
   // frames have gone by the prediction is held at zero and primed is low.
   task automatic forecast_frame();
      rsp_type fc;
      longint  acc;
      int      p;
      int      st;
      int      src;
      int      slot;
      bit      warm;
      if (frames_done < ORDER + 1)
         frames_done++;
      warm = (frames_done >= ORDER + 1);
      for (p = 0; p < NCH; p++) begin
         acc = 0;
         if (warm) begin
            for (st = 0; st < ORDER; st++) begin
               // step 0 is the frame just written at the ring head
               slot = (ring_head + ORDER - st) % ORDER;
               for (src = 0; src < NCH; src++)
                  acc += longint'(tap_model[st*NCH*NCH + p*NCH + src])
                         * longint'(hist_model[slot][src]);
            end
            // round half up, then floor; no rounding term at shift zero
            if (shift_model != 0)
               acc += longint'(1) <<< (shift_model - 1);
            acc = acc >>> shift_model;
            if (acc > PRED_MAX)
               acc = PRED_MAX;
            if (acc < PRED_MIN)
               acc = PRED_MIN;
         end
         fc.out_channel = CH_W'(p);
         fc.prediction  = acc[PRED_W-1:0];
         fc.primed      = warm;
         fc.last        = (p == NCH - 1);
         forecast_q.push_back(fc);
      end
      ring_head = (ring_head + 1) % ORDER;
   endtask

   // Apply one accepted transaction to the model
   task automatic absorb_item(input req_type item);
      if (item.cmd == CMD_COEF) begin
         // addresses past the tap store are dropped by the block
         if (item.coef_index < TAP_COUNT)
            tap_model[item.coef_index] = item.coef_value;
         n_tap_writes++;
      end else begin
         hist_model[ring_head][fill_pos] = item.sample;
         if (fill_pos + 1 < NCH) begin
            fill_pos++;
         end else begin
            fill_pos = 0;
            n_frames++;
            forecast_frame();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Transaction builders and drivers
   // ------------------------------------------------------------------------

   // Full-range 16-bit word, weighted toward the corners
   function automatic logic [15:0] pick_word();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Unused fields carry random junk; the block must ignore them
   function automatic req_type tap_txn(input int index, input logic [15:0] value);
      req_type item;
      item.cmd        = CMD_COEF;
      item.coef_index = CIDX_W'(index);
      item.coef_value = value;
      item.sample     = SAMP_W'($urandom);
      return item;
   endfunction

   function automatic req_type sample_txn(input logic [15:0] value);
      req_type item;
      item.cmd        = CMD_SAMPLE;
      item.coef_index = CIDX_W'($urandom);
      item.coef_value = COEF_W'($urandom);
      item.sample     = value;
      return item;
   endfunction

   // Present one transaction, hold it through stalls, model it on acceptance.
   // Valid is only ever lowered in a step where nothing raises it again.
   task automatic send_item(input req_type item);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      absorb_item(item);
   endtask

   task automatic send_frame_of(input logic [15:0] value);
      int k;
      for (k = 0; k < NCH; k++)
         send_item(sample_txn(value));
   endtask

   // Hold the sender until every forecast result has been seen
   task automatic wait_for_forecasts();
      req_valid <= 1'b0;
      do @(posedge clock); while (forecast_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle
   task automatic reconfigure_shift(input logic [SHIFT_W-1:0] value);
      wait_for_forecasts();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shift_model = value;
      n_shift_writes++;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls and in-order checking
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (forecast_q.size() == 0) begin
            n_errors++;
            $display("%0t: result with nothing expected, expected none actual %p",
                     $time, rsp_data);
         end else begin
            want = forecast_q.pop_front();
            check_field("out_channel", 32'(want.out_channel), 32'(rsp_data.out_channel));
            check_field("prediction",  32'(want.prediction),  32'(rsp_data.prediction));
            check_field("primed",      32'(want.primed),      32'(rsp_data.primed));
            check_field("last",        32'(want.last),        32'(rsp_data.last));
            n_checked++;
         end
      end
   end

   // Watchdog: too long without any transaction on any channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, forecast_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // First ORDER frames: results carry zero and primed low. Taps are not
   // needed yet, so the store stays untouched apart from two writes dropped
   // into the middle of a frame.
   task automatic test_unprimed_frames();
      int k;
      send_frame_of(16'h8000);
      send_frame_of(16'h7FFF);
      for (k = 0; k < NCH; k++) begin
         if (k == 3)
            send_item(tap_txn(0, 16'h8000));
         if (k == 5)
            send_item(tap_txn(TAP_COUNT - 1, 16'h7FFF));
         send_item(sample_txn(k[0] ? 16'hAAAA : 16'h5555));
      end
      for (k = 0; k < NCH; k++)
         send_item(sample_txn(k[0] ? 16'hFFFF : 16'h0001));
   endtask

   // Every tap gets written before any primed frame reads the store.
   // Channel 0 taps at max, channel 1 at min, channel 2 zero, channel 3
   // alternating +/-1 (tiny sums for rounding), the rest random.
   task automatic test_tap_load();
      int idx;
      int pred;
      logic [15:0] value;
      for (idx = 0; idx < TAP_COUNT; idx++) begin
         pred = (idx / NCH) % NCH;
         case (pred)
            0:       value = 16'h7FFF;
            1:       value = 16'h8000;
            2:       value = 16'h0000;
            3:       value = idx[0] ? 16'hFFFF : 16'h0001;
            default: value = pick_word();
         endcase
         send_item(tap_txn(idx, value));
      end
   endtask

   // Frames at and after the priming point, shift still at its reset value
   task automatic test_first_primed();
      send_frame_of(16'h7FFF);
      send_frame_of(16'h8000);
   endtask

   // Shift extremes: zero (no rounding, both saturation rails), 31, 1, and
   // the reset value written explicitly
   task automatic test_shift_extremes();
      int k;
      reconfigure_shift(5'd0);
      send_frame_of(16'h8000);
      send_frame_of(16'h7FFF);
      reconfigure_shift(5'd31);
      send_frame_of(16'h8000);
      reconfigure_shift(5'd1);
      for (k = 0; k < NCH; k++)
         send_item(sample_txn(pick_word()));
      reconfigure_shift(SHIFT_RESET);
      send_frame_of(16'h0001);
   endtask

   // Mostly whole frames with random content, sprinkled with tap rewrites;
   // the rest are stray tap bursts and short sample runs that move the frame
   // boundary. The shift changes between segments; one segment runs flat out.
   task automatic test_random_traffic();
      int sent;
      int segment;
      int k;
      int run;
      sent    = 0;
      segment = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 85) begin
            for (k = 0; k < NCH; k++) begin
               if ($urandom_range(99) < 8) begin
                  send_item(tap_txn($urandom_range(TAP_COUNT - 1), pick_word()));
                  sent++;
               end
               send_item(sample_txn(pick_word()));
               sent++;
            end
         end else if ($urandom_range(1) == 0) begin
            run = $urandom_range(4, 1);
            for (k = 0; k < run; k++)
               send_item(tap_txn($urandom_range(TAP_COUNT - 1), pick_word()));
            sent += run;
         end else begin
            run = $urandom_range(NCH - 1, 1);
            for (k = 0; k < run; k++)
               send_item(sample_txn(pick_word()));
            sent += run;
         end
         if (sent >= (segment + 1) * SEGMENT_ITEMS) begin
            segment++;
            steady = (segment == 1);
            // mid-range shifts keep most sums off the rails
            reconfigure_shift(SHIFT_W'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                              : $urandom_range(20, 8)));
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_unprimed_frames();
      test_tap_load();
      test_first_primed();
      test_shift_extremes();
      test_random_traffic();

      // drain, then give any stray result time to show up
      wait_for_forecasts();
      repeat (END_CYCLES) @(posedge clock);

      $display("Run covered %0d frames with %0d channel results checked,",
               n_frames, n_checked);
      $display("%0d tap writes and %0d shift settings.", n_tap_writes, n_shift_writes);
      if (n_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: mimo_fir_predictor_top.f
rtl/core/mfp_pkg.sv
rtl/core/mimo_fir_predictor_top.sv
tb/sv/tb_mimo_fir_predictor_top.sv
